FILE: rtl/csca_pkg.sv
`timescale 1ns / 1ps

package csca_pkg;

    localparam int DATA_W        = 21;
    localparam int XY_IN_W       = 16;
    localparam int ANGLE_IN_W    = 20;
    localparam int FRACTION_BITS = 12;
    localparam int GAIN_W        = 14;
    localparam int PROD_W        = DATA_W + GAIN_W - 1;
    localparam int CMD_W         = 2;
    localparam int ATAN_ENTRIES  = 24;
    localparam int ITERATIONS_DEF = 16;

    localparam int S_TDATA_W = ((2 * XY_IN_W + ANGLE_IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;

    localparam logic signed [GAIN_W-1:0] CORDIC_GAIN = 14'sd2487;

    typedef enum logic [CMD_W-1:0] {
        CMD_COS  = 2'd0,
        CMD_SIN  = 2'd1,
        CMD_ATAN = 2'd2
    } t_cmd;

    // arctan(2^-i) in degrees, Q.12, truncated
    localparam logic signed [DATA_W-1:0] ATAN_DEG [ATAN_ENTRIES] = '{
        21'sd184320, 21'sd108810, 21'sd57492, 21'sd29184,
        21'sd14648,  21'sd7331,   21'sd3666,  21'sd1833,
        21'sd916,    21'sd458,    21'sd229,   21'sd114,
        21'sd57,     21'sd28,     21'sd14,    21'sd7,
        21'sd3,      21'sd1,      21'sd0,     21'sd0,
        21'sd0,      21'sd0,      21'sd0,     21'sd0
    };

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] theta;
    } t_cordic;

endpackage

FILE: rtl/csca_stage.sv
`timescale 1ns / 1ps

module csca_stage #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  csca_pkg::t_cordic i_data,
    output logic              o_valid,
    output csca_pkg::t_cordic o_data
);
    import csca_pkg::*;

    logic                     r_valid;
    t_cordic                  r_data;
    t_cordic                  n_data;
    logic signed [DATA_W-1:0] w_x;
    logic signed [DATA_W-1:0] w_y;
    logic signed [DATA_W-1:0] w_x_sh;
    logic signed [DATA_W-1:0] w_y_sh;
    logic                     w_dir;

    assign w_x    = i_data.x;
    assign w_y    = i_data.y;
    assign w_x_sh = w_x >>> STAGE;
    assign w_y_sh = w_y >>> STAGE;
    // vectoring drives y toward zero, rotation drives the angle toward zero
    assign w_dir  = (i_data.cmd == CMD_ATAN) ? w_y[DATA_W-1]
                                             : (!i_data.theta[DATA_W-1] &&
                                                (i_data.theta != '0));

    always_comb begin
        n_data.cmd = i_data.cmd;
        if (w_dir) begin
            n_data.x     = w_x - w_y_sh;
            n_data.y     = w_y + w_x_sh;
            n_data.theta = i_data.theta - ATAN_DEG[STAGE];
        end else begin
            n_data.x     = w_x + w_y_sh;
            n_data.y     = w_y - w_x_sh;
            n_data.theta = i_data.theta + ATAN_DEG[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/cordic_sin_cos_atan_degrees.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   x_in[15:0] y_in[31:16] angle_in[51:32] pad  cmd[1:0]
// m_axis    out  result_value[20:0] pad                      -
//
// One transaction per cycle sustained while the output is not stalled; the
// pipeline has one register stage per micro-rotation, one for the gain
// multiply and one output register.
// Synchronous active-low reset clears the valid bits only.
// A stalled output holds the whole pipeline; bubbles travel with it.

module cordic_sin_cos_atan_degrees #(
    parameter int ITERATIONS = csca_pkg::ITERATIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // x_in, y_in, angle_in, zero pad
    input  logic [csca_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd
    input  logic [csca_pkg::CMD_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // result_value, zero pad
    output logic [csca_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import csca_pkg::*;

    logic                         w_en;
    logic                         w_accept;
    logic [ITERATIONS:0]          w_valid;
    t_cordic                      w_data [ITERATIONS+1];
    logic signed [XY_IN_W-1:0]    w_x_in;
    logic signed [XY_IN_W-1:0]    w_y_in;
    logic signed [ANGLE_IN_W-1:0] w_angle_in;

    logic                         r_mul_valid;
    t_cmd                         r_mul_cmd;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [DATA_W-1:0]     r_mul_theta;
    logic signed [DATA_W-1:0]     w_sel;
    logic signed [PROD_W-1:0]     w_prod_sh;

    logic                         r_out_valid;
    logic signed [DATA_W-1:0]     r_result;
    logic signed [DATA_W-1:0]     n_result;

    // advance everything unless the output register is full and stalled
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid && w_en;

    assign w_x_in     = i_s_axis_tdata[XY_IN_W-1:0];
    assign w_y_in     = i_s_axis_tdata[2*XY_IN_W-1:XY_IN_W];
    assign w_angle_in = i_s_axis_tdata[2*XY_IN_W+ANGLE_IN_W-1:2*XY_IN_W];

    assign w_valid[0]      = i_s_axis_tvalid;
    assign w_data[0].cmd   = t_cmd'(i_s_axis_tuser);
    assign w_data[0].x     = DATA_W'(w_x_in);
    assign w_data[0].y     = DATA_W'(w_y_in);
    assign w_data[0].theta = DATA_W'(w_angle_in);

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
        csca_stage #(
            .STAGE(g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_valid[g]),
            .i_data (w_data[g]),
            .o_valid(w_valid[g+1]),
            .o_data (w_data[g+1])
        );
    end

    assign w_sel = (w_data[ITERATIONS].cmd == CMD_SIN) ? w_data[ITERATIONS].y
                                                       : w_data[ITERATIONS].x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_en) begin
            r_mul_valid <= w_valid[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul_cmd   <= w_data[ITERATIONS].cmd;
            r_mul_theta <= w_data[ITERATIONS].theta;
            r_prod      <= PROD_W'(w_sel) * PROD_W'(CORDIC_GAIN);
        end
    end

    assign w_prod_sh = r_prod >>> FRACTION_BITS;

    always_comb begin
        unique case (r_mul_cmd) inside
            CMD_COS, CMD_SIN: n_result = w_prod_sh[DATA_W-1:0];
            default:          n_result = r_mul_theta;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - DATA_W){1'b0}}, r_result};

    a_enter_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_valid[1])
        else $error("accepted transaction missing from first stage");

    a_stall_holds_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid[ITERATIONS:1]) && $stable(r_mul_valid))
        else $error("pipeline valid bits moved during a stall");

    a_out_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_mul_valid))
        else $error("output valid without a multiply-stage transaction");

endmodule

FILE: tb/cordic_result_checker.sv
`timescale 1ns / 1ps

module cordic_result_checker #(
    parameter int ITERATIONS = csca_pkg::ITERATIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // x_in[15:0], y_in[31:16], angle_in[51:32], zero pad
    input  logic [csca_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [csca_pkg::CMD_W-1:0]     i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // result_value[20:0], zero pad
    input  logic [csca_pkg::M_TDATA_W-1:0] i_m_axis_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import csca_pkg::*;

    localparam int GAIN_Q12 = 2487;
    localparam int MAX_REPORTS = 10;

    // arctan(2^-k) in degrees, Q.12, truncated
    localparam longint ATAN_STEP [24] = '{
        184320, 108810, 57492, 29184, 14648, 7331, 3666, 1833,
        916, 458, 229, 114, 57, 28, 14, 7,
        3, 1, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [19:0] angle;
        logic [DATA_W-1:0]  value;
    } t_cordic_expect;

    t_cordic_expect expected_results[$];
    t_cordic_expect head;
    t_cordic_expect incoming;
    logic [DATA_W-1:0] seen;
    int mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [DATA_W-1:0] cordic_result(
        input logic [CMD_W-1:0]   op,
        input logic signed [15:0] x0,
        input logic signed [15:0] y0,
        input logic signed [19:0] angle0
    );
        longint xa;
        longint yb;
        longint th;
        longint nx;
        longint ny;
        longint step;
        longint value;
        bit     rotate_pos;
        xa = x0;
        yb = y0;
        th = angle0;
        for (int k = 0; k < ITERATIONS; k++) begin
            step = (k < 24) ? ATAN_STEP[k] : 0;
            // vectoring drives y to zero, rotation drives the angle to zero
            rotate_pos = (op == CMD_ATAN) ? (yb < 0) : (th > 0);
            if (rotate_pos) begin
                nx = xa - (yb >>> k);
                ny = yb + (xa >>> k);
                th = th - step;
            end else begin
                nx = xa + (yb >>> k);
                ny = yb - (xa >>> k);
                th = th + step;
            end
            xa = nx;
            yb = ny;
        end
        if (op == CMD_SIN)
            value = (yb * GAIN_Q12) >>> FRACTION_BITS;
        else if (op == CMD_COS)
            value = (xa * GAIN_Q12) >>> FRACTION_BITS;
        else
            value = th;
        return value[DATA_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen = i_m_axis_tdata[DATA_W-1:0];
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result %0d", $signed(seen)));
                end else begin
                    head = expected_results.pop_front();
                    if (seen !== head.value)
                        note_failure($sformatf(
                            "cmd %0d x %0d y %0d angle %0d: expected %0d, got %0d",
                            head.op, head.x, head.y, head.angle,
                            $signed(head.value), $signed(seen)));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                incoming.op    = i_s_axis_tuser;
                incoming.x     = i_s_axis_tdata[15:0];
                incoming.y     = i_s_axis_tdata[31:16];
                incoming.angle = i_s_axis_tdata[51:32];
                incoming.value = cordic_result(incoming.op, incoming.x, incoming.y,
                                               incoming.angle);
                expected_results.push_back(incoming);
            end
        end
        o_pending <= expected_results.size();
    end

    initial o_pending = 0;

endmodule

FILE: tb/tb_cordic_sin_cos_atan_degrees.sv
`timescale 1ns / 1ps

module tb_cordic_sin_cos_atan_degrees;

    import csca_pkg::*;

    localparam int ITER = ITERATIONS_DEF;
    localparam logic [CMD_W-1:0] CMD_ROT_RESIDUAL = 2'd3;
    localparam int ANGLE_SPAN = 409600;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = CMD_COS;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int hold_off_left = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cordic_sin_cos_atan_degrees #(
        .ITERATIONS(ITER)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    cordic_result_checker #(
        .ITERATIONS(ITER)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_m_axis_tdata (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // result consumer: random back-pressure, or a counted hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left = hold_off_left - 1;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 29);
            end
        end
    end

    task automatic send_item(
        input logic [CMD_W-1:0] op,
        input logic [15:0]      x,
        input logic [15:0]      y,
        input logic [19:0]      angle
    );
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, angle, y, x};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random();
        int pick;
        int angle;
        int jitter;
        pick  = $urandom_range(99);
        angle = int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
        jitter = int'($urandom_range(64)) - 32;
        if (pick < 20)
            send_item(CMD_COS, 16'(4096 + jitter), 16'(jitter), angle[19:0]);
        else if (pick < 40)
            send_item(CMD_SIN, 16'(4096 + jitter), 16'(jitter), angle[19:0]);
        else if (pick < 65)
            send_item(CMD_ATAN, 16'($urandom), 16'($urandom),
                      ($urandom_range(3) == 0) ? angle[19:0] : 20'd0);
        else if (pick < 75)
            send_item(CMD_ROT_RESIDUAL, 16'($urandom), 16'($urandom), 20'($urandom));
        else
            send_item(CMD_W'($urandom_range(3)), 16'($urandom), 16'($urandom),
                      20'($urandom));
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit vector, zero and textbook angles
        send_item(CMD_COS, 16'sd4096, 16'sd0, 20'sd0);
        send_item(CMD_SIN, 16'sd4096, 16'sd0, 20'sd122880);
        send_item(CMD_SIN, 16'sd32767, 16'sd32767, 20'sd1);
        // field extremes
        send_item(CMD_COS, 16'sd32767, -16'sd32768, 20'sd524287);
        send_item(CMD_SIN, -16'sd32768, 16'sd32767, -20'sd524288);
        send_item(CMD_COS, -16'sd1, -16'sd1, -20'sd409600);
        send_item(CMD_SIN, 16'sd0, 16'sd0, 20'sd409600);
        // vectoring
        send_item(CMD_ATAN, 16'sd4096, 16'sd4096, 20'sd0);
        send_item(CMD_ATAN, 16'sd32767, -16'sd32768, 20'sd0);
        send_item(CMD_ATAN, -16'sd32768, -16'sd32768, -20'sd524288);
        send_item(CMD_ATAN, 16'sd0, 16'sd0, 20'sd524287);
        // unused command steps like rotation and returns the residual angle
        send_item(CMD_ROT_RESIDUAL, 16'sd4096, 16'sd4096, 20'sd368640);
        send_item(CMD_ROT_RESIDUAL, -16'sd1, -16'sd1, -20'sd1);
        send_item(CMD_ROT_RESIDUAL, 16'sd32767, -16'sd32768, 20'sd524287);

        repeat (150) send_random();

        // pause until the pipeline is empty
        s_tvalid <= 1'b0;
        wait_drained();

        calm = 1'b1;
        repeat (100) send_random();
        calm = 1'b0;

        // stall the output long enough to back the pipeline up
        hold_off_left = 250;
        repeat (80) send_random();

        repeat (110) send_random();
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (ITER + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/csca_pkg.sv
rtl/csca_stage.sv
rtl/cordic_sin_cos_atan_degrees.sv
tb/cordic_result_checker.sv
tb/tb_cordic_sin_cos_atan_degrees.sv
